/* rtl/core/lesq_pkg.sv */
// Package for the largest empty square finder core.
// Holds the default grid limits, port widths and configuration register codes.
// No dependencies.
package lesq_pkg;

    // Default grid limits, used as the top-level parameter defaults.
    localparam int MAX_ROWS_DEFAULT = 1024;
    localparam int MAX_COLS_DEFAULT = 1024;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // Reset value of both count registers.
    localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 11'd1024;

    // Result word field widths.
    localparam int TOP_ROW_W  = 10;
    localparam int LEFT_COL_W = 10;
    localparam int SIDE_W     = 11;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1
    } cfg_reg_t;

endpackage

/* rtl/core/lesq_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Used as the line buffer of the largest empty square finder; no dependencies.
module lesq_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read of the entry written in the same cycle returns old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/largest_empty_square_finder_core.sv */
// Top level of the largest empty square finder: streaming maximal-square search.
// Depends on lesq_pkg (constants, register codes) and lesq_ram (line buffer).
//
//  channel | signals                                   | direction | word
//  --------+-------------------------------------------+-----------+------------------------
//  in      | in_valid, in_ready, cell_empty            | into core | one grid cell
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into core | one register write
//  out     | out_valid, out_ready, found, top_row,     | out of    | one result per grid
//          | left_col, side                            | core      |
//
// The core takes one cell word per clock cycle while the input is not stalled.
// Each cell goes through two stages: at acceptance the line buffer entry of its
// column is read, and in the second stage the square size is formed and written
// back to the same entry. The output register takes the result word when the last
// cell of the grid leaves the second stage. Reset clears the position, best-square
// and handshake state; the line buffer needs no clearing because the size read for
// the first row is forced to zero. The input stalls only when a grid ends while the
// previous result word waits to be taken. The configuration port is always ready.
module largest_empty_square_finder_core #(
    parameter int MAX_ROWS = lesq_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLS = lesq_pkg::MAX_COLS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lesq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lesq_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cell_empty,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [lesq_pkg::TOP_ROW_W-1:0]   top_row,
    output logic [lesq_pkg::LEFT_COL_W-1:0]  left_col,
    output logic [lesq_pkg::SIDE_W-1:0]      side
);

    import lesq_pkg::*;

    // Row and column index widths, count widths, and the square size width.
    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW     = RW + 1;
    localparam int CCW     = CW + 1;
    localparam int MIN_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SW      = $clog2(MIN_DIM + 1);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] row_count_reg;
    logic [CFG_DATA_W-1:0] col_count_reg;

    // Position of the next cell to be accepted.
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic [CW-1:0] col_pos_reg, col_pos_next;

    // Second stage: the cell whose line buffer entry has been read.
    logic          s2_valid_reg;
    logic          s2_cell_reg;
    logic [RW-1:0] s2_row_reg;
    logic [CW-1:0] s2_col_reg;
    logic          s2_last_reg;
    logic          byp_hit_reg;
    logic [SW-1:0] byp_data_reg;

    // Running sizes along the current row.
    logic [SW-1:0] left_size_reg, left_size_next;
    logic [SW-1:0] diag_size_reg, diag_size_next;

    // Best square of the current grid.
    logic [SW-1:0] best_side_reg, best_side_next;
    logic [RW-1:0] best_top_reg,  best_top_next;
    logic [CW-1:0] best_left_reg, best_left_next;

    // Output register.
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [TOP_ROW_W-1:0]  top_row_reg;
    logic [LEFT_COL_W-1:0] left_col_reg;
    logic [SIDE_W-1:0]     side_reg;

    logic [RCW-1:0] rows_eff;
    logic [CCW-1:0] cols_eff;
    logic           in_accept;
    logic           s2_stall;
    logic           s2_fire;
    logic           row_end;
    logic           grid_end;
    logic [SW-1:0]  ram_rd_data;
    logic [SW-1:0]  up_raw;
    logic [SW-1:0]  up_size;
    logic [SW-1:0]  left_in;
    logic [SW-1:0]  diag_in;
    logic [SW-1:0]  min_ul;
    logic [SW-1:0]  min3;
    logic [SW-1:0]  size;
    logic           new_best;

    logic [RW+TOP_ROW_W-1:0]  top_ext;
    logic [CW+LEFT_COL_W-1:0] left_ext;
    logic [SW+SIDE_W-1:0]     side_ext;

    // ------------------------------------------------------------------
    // Configuration. A count of zero acts as one, and a count above the
    // grid limit acts as the limit.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= COUNT_RESET;
            col_count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data;
                REG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = RCW'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = RCW'(row_count_reg);

        if (col_count_reg == '0)
            cols_eff = CCW'(1);
        else if (32'(col_count_reg) > MAX_COLS)
            cols_eff = CCW'(MAX_COLS);
        else
            cols_eff = CCW'(col_count_reg);
    end

    // ------------------------------------------------------------------
    // Handshake. The second stage holds only when it carries the last cell
    // of a grid and the output register is still occupied; the input then
    // waits so the line buffer read data stays in place.
    // ------------------------------------------------------------------
    assign s2_stall  = s2_valid_reg && s2_last_reg && out_valid_reg && !out_ready;
    assign s2_fire   = s2_valid_reg && !s2_stall;
    assign in_ready  = !s2_stall;
    assign in_accept = in_valid && in_ready;

    // ------------------------------------------------------------------
    // First stage: raster position. A shrunk count ends the row or the
    // grid after the current cell.
    // ------------------------------------------------------------------
    always_comb
    begin
        row_end  = (32'(col_pos_reg) + 32'd1) >= 32'(cols_eff);
        grid_end = row_end && ((32'(row_pos_reg) + 32'd1) >= 32'(rows_eff));

        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg + CW'(1);
        if (row_end)
        begin
            col_pos_next = '0;
            row_pos_next = grid_end ? '0 : row_pos_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            if (in_accept)
                s2_valid_reg <= 1'b1;
            else if (s2_fire)
                s2_valid_reg <= 1'b0;
        end
    end

    // Stage payload. When a single-column grid writes an entry in the same
    // cycle that the next cell reads it, the new size is forwarded.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_cell_reg  <= cell_empty;
            s2_row_reg   <= row_pos_reg;
            s2_col_reg   <= col_pos_reg;
            s2_last_reg  <= grid_end;
            byp_hit_reg  <= s2_fire && (s2_col_reg == col_pos_reg);
            byp_data_reg <= size;
        end
    end

    // Line buffer of square sizes of the previous row.
    lesq_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (s2_fire),
        .wr_addr (s2_col_reg),
        .wr_data (size),
        .rd_en   (in_accept),
        .rd_addr (col_pos_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Second stage: size of the largest empty square whose bottom-right
    // corner is this cell, and the best-square update.
    // ------------------------------------------------------------------
    always_comb
    begin
        up_raw  = byp_hit_reg ? byp_data_reg : ram_rd_data;
        up_size = (s2_row_reg == '0) ? '0 : up_raw;
        left_in = (s2_col_reg == '0) ? '0 : left_size_reg;
        diag_in = ((s2_row_reg == '0) || (s2_col_reg == '0)) ? '0 : diag_size_reg;

        min_ul = (up_size < left_in) ? up_size : left_in;
        min3   = (min_ul < diag_in) ? min_ul : diag_in;
        size   = s2_cell_reg ? (min3 + SW'(1)) : '0;

        new_best       = size > best_side_reg;
        best_side_next = best_side_reg;
        best_top_next  = best_top_reg;
        best_left_next = best_left_reg;
        if (new_best)
        begin
            best_side_next = size;
            best_top_next  = RW'(32'(s2_row_reg) + 32'd1 - 32'(size));
            best_left_next = CW'(32'(s2_col_reg) + 32'd1 - 32'(size));
        end

        diag_size_next = s2_last_reg ? '0 : up_size;
        left_size_next = s2_last_reg ? '0 : size;

        top_ext  = {{TOP_ROW_W{1'b0}}, best_top_next};
        left_ext = {{LEFT_COL_W{1'b0}}, best_left_next};
        side_ext = {{SIDE_W{1'b0}}, best_side_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_size_reg <= '0;
            diag_size_reg <= '0;
            best_side_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
        end
        else if (s2_fire)
        begin
            left_size_reg <= left_size_next;
            diag_size_reg <= diag_size_next;
            if (s2_last_reg)
            begin
                best_side_reg <= '0;
                best_top_reg  <= '0;
                best_left_reg <= '0;
            end
            else
            begin
                best_side_reg <= best_side_next;
                best_top_reg  <= best_top_next;
                best_left_reg <= best_left_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register, loaded with the best square when a grid ends.
    // A grid with no empty cell reports all zero fields.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_fire && s2_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && s2_last_reg)
        begin
            found_reg    <= best_side_next != '0;
            top_row_reg  <= (best_side_next != '0) ? top_ext[TOP_ROW_W-1:0] : '0;
            left_col_reg <= (best_side_next != '0) ? left_ext[LEFT_COL_W-1:0] : '0;
            side_reg     <= side_ext[SIDE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign top_row   = top_row_reg;
    assign left_col  = left_col_reg;
    assign side      = side_reg;

endmodule
